>>> hw/rtl/range_sensor_offset_calibrator_unit_macros.svh
// Assertion macros used by the checker file of the offset calibrator.
`ifndef RANGE_SENSOR_OFFSET_CALIBRATOR_UNIT_MACROS_SVH
`define RANGE_SENSOR_OFFSET_CALIBRATOR_UNIT_MACROS_SVH

// Condition on the left holds, so the consequence holds in the same cycle.
`define RSOC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rsoc same-cycle check failed");

// Condition on the left holds, so the consequence holds in the next cycle.
`define RSOC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rsoc next-cycle check failed");

`endif

>>> hw/rtl/rsoc_pkg.sv
`default_nettype none

package rsoc_pkg;

    localparam int RD_W    = 13;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 6;
    localparam int SIDE_W  = 3;
    localparam int ID_W    = 4;
    localparam int CONF_W  = 4;
    localparam int NSLOT   = 4;
    localparam int NSLOT_W = 3;

    // Reciprocal for the mean: exact for any 19-bit sum and any divisor below 64.
    localparam int MEAN_K = SUM_W + CNT_W;
    // Reciprocal for the four-fifths step on a 15-bit operand.
    localparam int FIFTH_K = 18;
    localparam logic [16:0] FIFTH_M = 17'd52429;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    typedef enum logic [1:0] {
        PH_DETECT  = 2'd0,
        PH_AVERAGE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_MAP     = 3'd0,
        REG_COUNTS  = 3'd1,
        REG_VMIN    = 3'd2,
        REG_VMAX    = 3'd3,
        REG_NEAR    = 3'd4,
        REG_CONFIRM = 3'd5
    } reg_idx_t;

    localparam logic [SIDE_W-1:0] SIDE_ALL_DONE = 3'd4;

    typedef struct packed {
        logic [63:0]       side_sensor_map;
        logic [7:0]        side_sensor_counts;
        logic [RD_W-1:0]   valid_min;
        logic [RD_W-1:0]   valid_max;
        logic [RD_W-1:0]   near_threshold;
        logic [CONF_W-1:0] confirm_frames;
    } cfg_t;

    // One unit of work for the back end: a status result or a finished side.
    typedef struct packed {
        logic                         is_offset;
        logic [SIDE_W-1:0]            side;
        phase_t                       phase;
        logic [NSLOT_W-1:0]           nslots;
        logic [NSLOT-1:0][SUM_W-1:0]  sums;
        logic [NSLOT-1:0][ID_W-1:0]   ids;
    } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsoc_regs.sv
`default_nettype none

module rsoc_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rsoc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rsoc_pkg::DATA_W-1:0]  pwdata,
    output logic      [rsoc_pkg::DATA_W-1:0]  prdata,
    output rsoc_pkg::cfg_t                    cfg
);

    rsoc_pkg::cfg_t   cfg_reg;
    rsoc_pkg::cfg_t   cfg_next;
    rsoc_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx   = rsoc_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                rsoc_pkg::REG_MAP:     cfg_next.side_sensor_map    = pwdata;
                rsoc_pkg::REG_COUNTS:  cfg_next.side_sensor_counts = pwdata[7:0];
                rsoc_pkg::REG_VMIN:    cfg_next.valid_min          = pwdata[12:0];
                rsoc_pkg::REG_VMAX:    cfg_next.valid_max          = pwdata[12:0];
                rsoc_pkg::REG_NEAR:    cfg_next.near_threshold     = pwdata[12:0];
                rsoc_pkg::REG_CONFIRM: cfg_next.confirm_frames     = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rsoc_pkg::REG_MAP:     prdata = cfg_reg.side_sensor_map;
            rsoc_pkg::REG_COUNTS:  prdata = 64'(cfg_reg.side_sensor_counts);
            rsoc_pkg::REG_VMIN:    prdata = 64'(cfg_reg.valid_min);
            rsoc_pkg::REG_VMAX:    prdata = 64'(cfg_reg.valid_max);
            rsoc_pkg::REG_NEAR:    prdata = 64'(cfg_reg.near_threshold);
            rsoc_pkg::REG_CONFIRM: prdata = 64'(cfg_reg.confirm_frames);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.side_sensor_map    <= '0;
            cfg_reg.side_sensor_counts <= 8'd191;
            cfg_reg.valid_min          <= 13'd15;
            cfg_reg.valid_max          <= 13'd2000;
            cfg_reg.near_threshold     <= 13'd60;
            cfg_reg.confirm_frames     <= 4'd3;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rsoc_front.sv
`default_nettype none

module rsoc_front #(
    parameter int SAMPLES = 50,
    parameter int SIDES   = 4,
    parameter int SLOTS   = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rsoc_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [rsoc_pkg::NSLOT-1:0][rsoc_pkg::RD_W-1:0] readings,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output rsoc_pkg::job_t       push_job
);

    logic [rsoc_pkg::SIDE_W-1:0]                          side_reg, side_next;
    rsoc_pkg::phase_t                                     phase_reg, phase_next;
    logic [rsoc_pkg::CONF_W-1:0]                          confirm_reg, confirm_next;
    logic [rsoc_pkg::CNT_W-1:0]                           samp_reg, samp_next;
    logic [rsoc_pkg::NSLOT-1:0][rsoc_pkg::SUM_W-1:0]      sums_reg, sums_next;

    logic accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid & push_ready;

    always_comb begin
        logic [1:0]                   cnt_code;
        logic [rsoc_pkg::NSLOT_W-1:0] n;
        logic                         have;
        logic [rsoc_pkg::RD_W-1:0]    mn;
        logic [rsoc_pkg::CONF_W-1:0]  conf_upd;
        logic [rsoc_pkg::CNT_W-1:0]   samp_upd;
        logic [rsoc_pkg::NSLOT-1:0][rsoc_pkg::SUM_W-1:0] sums_upd;

        side_next    = side_reg;
        phase_next   = phase_reg;
        confirm_next = confirm_reg;
        samp_next    = samp_reg;
        sums_next    = sums_reg;

        cnt_code = cfg.side_sensor_counts[{side_reg[1:0], 1'b0} +: 2];
        n = (cnt_code == 2'd0) ? 3'd4 : {1'b0, cnt_code};
        if (n > 3'(SLOTS)) begin
            n = 3'(SLOTS);
        end

        have = 1'b0;
        mn   = '0;
        for (int i = 0; i < rsoc_pkg::NSLOT; i++) begin
            if ((3'(i) < n) && (readings[i] > cfg.valid_min) &&
                (readings[i] < cfg.valid_max) && (!have || readings[i] < mn)) begin
                mn   = readings[i];
                have = 1'b1;
            end
        end

        conf_upd = '0;
        if (have && mn < cfg.near_threshold) begin
            conf_upd = (confirm_reg == 4'd15) ? confirm_reg : confirm_reg + 4'd1;
        end

        sums_upd = sums_reg;
        for (int i = 0; i < rsoc_pkg::NSLOT; i++) begin
            if (3'(i) < n) begin
                sums_upd[i] = sums_reg[i] + 19'(readings[i]);
            end
        end
        samp_upd = samp_reg + 6'd1;

        push_job.is_offset = 1'b0;
        push_job.side      = side_reg;
        push_job.phase     = phase_reg;
        push_job.nslots    = n;
        push_job.sums      = sums_upd;
        for (int i = 0; i < rsoc_pkg::NSLOT; i++) begin
            push_job.ids[i] = cfg.side_sensor_map[{side_reg[1:0], 2'(i), 2'b00} +: 4];
        end

        if (phase_reg == rsoc_pkg::PH_DONE || side_reg >= 3'(SIDES)) begin
            // Calibration complete: report and stay put.
            push_job.side  = rsoc_pkg::SIDE_ALL_DONE;
            push_job.phase = rsoc_pkg::PH_DONE;
            if (accept) begin
                phase_next = rsoc_pkg::PH_DONE;
            end
        end else if (phase_reg == rsoc_pkg::PH_DETECT) begin
            if (conf_upd >= cfg.confirm_frames) begin
                push_job.phase = rsoc_pkg::PH_AVERAGE;
            end
            if (accept) begin
                confirm_next = conf_upd;
                phase_next   = push_job.phase;
            end
        end else if (samp_upd < 6'(SAMPLES)) begin
            push_job.phase = rsoc_pkg::PH_AVERAGE;
            if (accept) begin
                sums_next = sums_upd;
                samp_next = samp_upd;
            end
        end else begin
            // Last sample of the side: hand the sums to the back end.
            push_job.is_offset = 1'b1;
            push_job.phase = (4'(side_reg) + 4'd1 >= 4'(SIDES)) ?
                             rsoc_pkg::PH_DONE : rsoc_pkg::PH_DETECT;
            if (accept) begin
                sums_next    = '0;
                samp_next    = '0;
                confirm_next = '0;
                side_next    = side_reg + 3'd1;
                phase_next   = push_job.phase;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg    <= '0;
            phase_reg   <= rsoc_pkg::PH_DETECT;
            confirm_reg <= '0;
            samp_reg    <= '0;
            sums_reg    <= '0;
        end else begin
            side_reg    <= side_next;
            phase_reg   <= phase_next;
            confirm_reg <= confirm_next;
            samp_reg    <= samp_next;
            sums_reg    <= sums_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rsoc_queue.sv
`default_nettype none

module rsoc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire rsoc_pkg::job_t  push_job,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output rsoc_pkg::job_t       pop_job
);

    rsoc_pkg::job_t                 mem [rsoc_pkg::QDEPTH];
    logic [rsoc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rsoc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rsoc_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != 3'(rsoc_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(do_push) - 3'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rsoc_back.sv
`default_nettype none

module rsoc_back #(
    parameter int SAMPLES = 50
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire rsoc_pkg::job_t  pop_job,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 out_kind,
    output logic [rsoc_pkg::SIDE_W-1:0] out_side,
    output logic [1:0]           out_phase,
    output logic [rsoc_pkg::ID_W-1:0]   out_id,
    output logic [rsoc_pkg::RD_W-1:0]   out_offset,
    output logic                 out_last
);

    localparam int MEAN_W = rsoc_pkg::MEAN_K + 1;
    localparam int PROD_W = rsoc_pkg::SUM_W + MEAN_W;
    localparam logic [63:0] MEAN_M =
        ((64'd1 << rsoc_pkg::MEAN_K) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);

    logic [1:0] slot_reg, slot_next;
    logic       v1_reg, out_valid_reg;
    logic       en, issue, item_last;

    logic                         k1_reg, last1_reg;
    logic [rsoc_pkg::SIDE_W-1:0]  side1_reg;
    logic [1:0]                   phase1_reg;
    logic [rsoc_pkg::ID_W-1:0]    id1_reg;
    logic [rsoc_pkg::RD_W-1:0]    mean1_reg;

    logic                         kind_reg, last_reg;
    logic [rsoc_pkg::SIDE_W-1:0]  side_reg;
    logic [1:0]                   phase_reg;
    logic [rsoc_pkg::ID_W-1:0]    id_reg;
    logic [rsoc_pkg::RD_W-1:0]    offset_reg;

    logic [rsoc_pkg::SUM_W-1:0]   sum_sel;
    logic [PROD_W-1:0]            mean_prod;
    logic [33:0]                  fifth_prod;

    // Pipeline moves whenever the output register is free or being emptied.
    assign en        = !out_valid_reg || out_ready;
    assign issue     = en && pop_valid;
    assign item_last = !pop_job.is_offset || ({1'b0, slot_reg} + 3'd1 == pop_job.nslots);
    assign pop_ready = en && item_last;

    always_comb begin
        slot_next = slot_reg;
        if (issue) begin
            slot_next = item_last ? 2'd0 : slot_reg + 2'd1;
        end
    end

    assign sum_sel    = pop_job.is_offset ? pop_job.sums[slot_reg] : '0;
    assign mean_prod  = PROD_W'(sum_sel) * PROD_W'(MEAN_M[MEAN_W-1:0]);
    assign fifth_prod = 34'({mean1_reg, 2'b00}) * 34'(rsoc_pkg::FIFTH_M);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
            if (en) begin
                v1_reg        <= issue;
                out_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg     <= pop_job.is_offset;
            last1_reg  <= item_last;
            side1_reg  <= pop_job.side;
            phase1_reg <= pop_job.phase;
            id1_reg    <= pop_job.is_offset ? pop_job.ids[slot_reg] : '0;
            mean1_reg  <= mean_prod[rsoc_pkg::MEAN_K +: rsoc_pkg::RD_W];

            kind_reg   <= k1_reg;
            last_reg   <= last1_reg;
            side_reg   <= side1_reg;
            phase_reg  <= phase1_reg;
            id_reg     <= id1_reg;
            offset_reg <= fifth_prod[rsoc_pkg::FIFTH_K +: rsoc_pkg::RD_W];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_side   = side_reg;
    assign out_phase  = phase_reg;
    assign out_id     = id_reg;
    assign out_offset = offset_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/range_sensor_offset_calibrator_unit.sv
// An accepted frame passes the job queue, the back-end stage register and the
// output register before its result shows on m_tvalid. Throughput: one frame per
// cycle while the queue has room; a frame that ends a side yields one result per
// active sensor (up to four), absorbed by the four-entry front-to-back job queue.
// Reset: aresetn is synchronous and active low; it clears calibration state,
// the queue and the pipeline, and restores the register defaults.
`default_nettype none

module range_sensor_offset_calibrator_unit #(
    parameter int SAMPLES = 50,
    parameter int SIDES   = 4,
    parameter int SLOTS   = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Frame input. s_tdata, from bit 0: reading_0, reading_1, reading_2,
    // reading_3 (13 bits each), then four zero bits.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,

    // Result output. m_tdata, from bit 0: side (3), phase (2), sensor_id (4),
    // offset_value (13), then two zero bits. m_tuser: kind. m_tlast: last.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast,

    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    rsoc_pkg::cfg_t  cfg;
    rsoc_pkg::job_t  push_job, pop_job;
    logic            push_valid, push_ready, pop_valid, pop_ready;

    logic                          out_kind, out_last;
    logic [rsoc_pkg::SIDE_W-1:0]   out_side;
    logic [1:0]                    out_phase;
    logic [rsoc_pkg::ID_W-1:0]     out_id;
    logic [rsoc_pkg::RD_W-1:0]     out_offset;

    // The register port never waits.
    assign pready = 1'b1;

    rsoc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The front end classifies each frame, updates the side, phase, confirm
    // counter and running sums, and turns every request into one job.
    rsoc_front #(
        .SAMPLES (SAMPLES),
        .SIDES   (SIDES),
        .SLOTS   (SLOTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .readings   (s_tdata[51:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // The queue lets the front end keep taking frames while the back end
    // works through the slots of a finished side or waits on m_tready.
    rsoc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // The back end walks the active slots of a job and computes each offset
    // as four fifths of the mean, using two reciprocal multiplications.
    rsoc_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_side   (out_side),
        .out_phase  (out_phase),
        .out_id     (out_id),
        .out_offset (out_offset),
        .out_last   (out_last)
    );

    assign m_tdata = {2'b00, out_offset, out_id, out_phase, out_side};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

`default_nettype wire

>>> hw/rtl/rsoc_checker.sv
`default_nettype none
`include "range_sensor_offset_calibrator_unit_macros.svh"

module rsoc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result keeps its contents.
    `RSOC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Status results carry no sensor and no offset and always close their frame.
    `RSOC_ASSERT_IMPL(a_status_shape, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && m_tdata[21:5] == 17'd0)

    // Once all sides are done only status results in the complete phase appear.
    `RSOC_ASSERT_IMPL(a_done_shape, aclk, aresetn, m_tvalid && m_tdata[2:0] == 3'd4, !m_tuser && m_tdata[4:3] == 2'd2)

    // An offset belongs to a real side and never exceeds four fifths of full scale.
    `RSOC_ASSERT_IMPL(a_offset_range, aclk, aresetn, m_tvalid && m_tuser, m_tdata[2:0] < 3'd4 && m_tdata[21:9] <= 13'd6552)

endmodule

bind range_sensor_offset_calibrator_unit rsoc_checker u_rsoc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
